// ----- rtl/core/mbps_pkg.sv -----
// Shared types, constants and register codes for the masked byte pattern search.
package mbps_pkg;

    // Sizes fixed by the pattern and stream formats.
    localparam int MAX_PATTERN = 16;
    localparam int BYTE_W      = 8;
    localparam int ADDR_W      = 32;
    localparam int LEN_W       = 5;
    localparam int MASK_W      = 16;
    localparam int WIN_IDX_W   = 4;
    localparam int WORD_W      = 64;

    // Configuration port geometry: eight-byte register spacing.
    localparam int APB_ADDR_W  = 6;
    localparam int APB_DATA_W  = 64;
    localparam int REG_IDX_W   = 3;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CARE_MASK    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LEN  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_REGION_BASE  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RESULT_OFS   = 3'd5;

    // Reset values of the registers.
    localparam logic [MASK_W-1:0] CARE_MASK_RESET  = 16'hFFFF;
    localparam logic [LEN_W-1:0]  PATTERN_LEN_RESET = 5'd1;

    // Byte window and pattern bytes, index 0 in the low bits.
    typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] byte_vec_t;

    // Search settings handed from the register file to the datapath.
    typedef struct packed {
        byte_vec_t          pattern;
        logic [MASK_W-1:0]  care;
        logic [LEN_W-1:0]   length;
        logic [ADDR_W-1:0]  base;
        logic [ADDR_W-1:0]  offset;
    } search_cfg_t;

endpackage

// ----- rtl/core/mbps_regs.sv -----
// Configuration register file behind the APB-style port.
module mbps_regs
    import mbps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output search_cfg_t           cfg
);

    logic [WORD_W-1:0] pattern_low_reg;
    logic [WORD_W-1:0] pattern_high_reg;
    logic [MASK_W-1:0] care_mask_reg;
    logic [LEN_W-1:0]  pattern_len_reg;
    logic [ADDR_W-1:0] region_base_reg;
    logic [ADDR_W-1:0] result_offset_reg;

    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg   <= '0;
            pattern_high_reg  <= '0;
            care_mask_reg     <= CARE_MASK_RESET;
            pattern_len_reg   <= PATTERN_LEN_RESET;
            region_base_reg   <= '0;
            result_offset_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_PATTERN_LOW:  pattern_low_reg   <= pwdata;
                REG_PATTERN_HIGH: pattern_high_reg  <= pwdata;
                REG_CARE_MASK:    care_mask_reg     <= pwdata[MASK_W-1:0];
                REG_PATTERN_LEN:  pattern_len_reg   <= pwdata[LEN_W-1:0];
                REG_REGION_BASE:  region_base_reg   <= pwdata[ADDR_W-1:0];
                REG_RESULT_OFS:   result_offset_reg <= pwdata[ADDR_W-1:0];
                default:          ;
            endcase
        end
    end

    // Read back.
    always_comb
    begin
        unique case (reg_idx)
            REG_PATTERN_LOW:  prdata = pattern_low_reg;
            REG_PATTERN_HIGH: prdata = pattern_high_reg;
            REG_CARE_MASK:    prdata = {{(APB_DATA_W-MASK_W){1'b0}}, care_mask_reg};
            REG_PATTERN_LEN:  prdata = {{(APB_DATA_W-LEN_W){1'b0}}, pattern_len_reg};
            REG_REGION_BASE:  prdata = {{(APB_DATA_W-ADDR_W){1'b0}}, region_base_reg};
            REG_RESULT_OFS:   prdata = {{(APB_DATA_W-ADDR_W){1'b0}}, result_offset_reg};
            default:          prdata = '0;
        endcase
    end

    // Settings for the datapath; lengths above the window size are clamped.
    always_comb
    begin
        cfg.pattern = {pattern_high_reg, pattern_low_reg};
        cfg.care    = care_mask_reg;
        cfg.length  = (pattern_len_reg > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                              : pattern_len_reg;
        cfg.base    = region_base_reg;
        cfg.offset  = result_offset_reg;
    end

endmodule

// ----- rtl/core/mbps_match.sv -----
// Parallel masked compare of the byte window against the pattern.
module mbps_match
    import mbps_pkg::*;
(
    input  byte_vec_t   window,
    input  search_cfg_t cfg,
    output logic        win_match
);

    logic [MAX_PATTERN-1:0] hit;

    // Window byte j lines up with pattern byte length-1-j; bytes past the
    // pattern length and wildcard bytes always agree.
    always_comb
    begin
        logic [LEN_W-1:0]     k_full;
        logic [WIN_IDX_W-1:0] k;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            k_full = cfg.length - LEN_W'(1) - LEN_W'(j);
            k      = k_full[WIN_IDX_W-1:0];
            hit[j] = (LEN_W'(j) >= cfg.length) || !cfg.care[k]
                     || (cfg.pattern[k] == window[j]);
        end
    end

    assign win_match = &hit;

endmodule

// ----- rtl/core/masked_byte_pattern_search.sv -----
// Top level: input register, window and match state, result register.
// A region's result is written into the result register when its last byte leaves
// the input register, and is held there until the receiver takes it.
// Throughput: one byte per cycle unless the input stalls; the window compare and
// address adders sit in one stage between the input and result registers.
// A held result stalls the input only when the next byte closes a region.
// Reset clears the window, position, match state and all valid flags at once;
// registers return to pattern zero, mask all ones, length one.
module masked_byte_pattern_search
    import mbps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Byte stream.
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [BYTE_W-1:0]     data_byte,
    input  logic                  last_byte,
    // Region results.
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  found,
    output logic [ADDR_W-1:0]     match_address,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    search_cfg_t cfg;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_data_reg;
    logic              in_last_reg;

    byte_vec_t         window_reg;
    logic [ADDR_W-1:0] pos_reg;
    logic              match_seen_reg;
    logic [ADDR_W-1:0] start_reg;

    logic              out_valid_reg;
    logic              found_reg;
    logic [ADDR_W-1:0] match_address_reg;

    byte_vec_t         window_next;
    logic              win_match;
    logic              pos_ok;
    logic              hit;
    logic              seen_now;
    logic [ADDR_W-1:0] start_now;
    logic              tail_ok;
    logic              found_next;
    logic [ADDR_W-1:0] match_address_next;
    logic              s1_go;
    logic              in_accept;

    mbps_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Flow control: only a region's last byte needs room in the result register.
    assign s1_go     = in_valid_reg && (!in_last_reg || !out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !s1_go;
    assign in_accept = in_valid && !in_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_data_reg <= data_byte;
            in_last_reg <= last_byte;
        end
    end

    // Shift the new byte in at the newest end of the window.
    assign window_next = {window_reg[MAX_PATTERN-2:0], in_data_reg};

    mbps_match u_match (
        .window    (window_next),
        .cfg       (cfg),
        .win_match (win_match)
    );

    // First-match tracking and the tail rule at the region's last byte.
    always_comb
    begin
        pos_ok = ({1'b0, pos_reg} + (ADDR_W+1)'(1)) >= (ADDR_W+1)'(cfg.length);
        if (cfg.length == '0)
        begin
            hit = !match_seen_reg && (pos_reg == '0);
        end
        else
        begin
            hit = !match_seen_reg && pos_ok && win_match;
        end
        seen_now = match_seen_reg || hit;
        if (!hit)
        begin
            start_now = start_reg;
        end
        else if (cfg.length == '0)
        begin
            start_now = '0;
        end
        else
        begin
            start_now = pos_reg + ADDR_W'(1) - ADDR_W'(cfg.length);
        end
        tail_ok = ((ADDR_W+2)'(start_now) + (ADDR_W+2)'(cfg.length) + (ADDR_W+2)'(1))
                  <= (ADDR_W+2)'(pos_reg);
        found_next = seen_now && tail_ok;
        match_address_next = found_next ? (cfg.base + start_now + cfg.offset) : '0;
    end

    // Stream state; a region's last byte returns it to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= '0;
            pos_reg        <= '0;
            match_seen_reg <= 1'b0;
            start_reg      <= '0;
        end
        else if (s1_go)
        begin
            if (in_last_reg)
            begin
                window_reg     <= '0;
                pos_reg        <= '0;
                match_seen_reg <= 1'b0;
                start_reg      <= '0;
            end
            else
            begin
                window_reg     <= window_next;
                pos_reg        <= pos_reg + ADDR_W'(1);
                match_seen_reg <= seen_now;
                start_reg      <= start_now;
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (s1_go && in_last_reg)
        begin
            found_reg         <= found_next;
            match_address_reg <= match_address_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign match_address = match_address_reg;

`ifndef ASSERT_OFF
    // A region with no accepted match reports address zero.
    a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> match_address_reg == '0)
        else $error("result without match carries a nonzero address");

    // The input stalls only behind a held result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg && out_stall && in_last_reg)
        else $error("input stalled without a held result");

    // Closing a region clears the position and match state.
    a_region_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && in_last_reg |=> pos_reg == '0 && !match_seen_reg)
        else $error("stream state not cleared after the last byte");

    // A match, once seen, holds until the region closes.
    a_match_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        match_seen_reg && !(s1_go && in_last_reg) |=> match_seen_reg)
        else $error("first match lost inside a region");
`endif

endmodule

// ----- tb/sv/masked_byte_pattern_search_tb.sv -----
// Self-checking testbench for the masked byte pattern search block.
module masked_byte_pattern_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mbps_pkg::*;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } stream_byte_t;

    typedef struct {
        logic              found;
        logic [ADDR_W-1:0] addr;
    } region_result_t;

    typedef enum int {REGION_NOISE, REGION_PLANTED, REGION_NEAR_MISS, REGION_TAIL} region_kind_t;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [BYTE_W-1:0]     data_byte = '0;
    logic                  last_byte = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  found;
    logic [ADDR_W-1:0]     match_address;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    masked_byte_pattern_search uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .match_address (match_address),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Bytes waiting to be sent and region results still owed by the block.
    stream_byte_t   byte_q[$];
    region_result_t result_q[$];

    // Our copy of the search registers.
    logic [WORD_W-1:0] pat_lo = '0;
    logic [WORD_W-1:0] pat_hi = '0;
    logic [MASK_W-1:0] care = CARE_MASK_RESET;
    logic [LEN_W-1:0]  plen = PATTERN_LEN_RESET;
    logic [ADDR_W-1:0] base = '0;
    logic [ADDR_W-1:0] ofs = '0;

    // Our copy of the scan state.
    logic [BYTE_W-1:0] win [MAX_PATTERN] = '{default: '0};
    logic [ADDR_W-1:0] pos = '0;
    logic [ADDR_W-1:0] first_start = '0;
    logic              seen = 1'b0;

    // Sender and receiver pacing.
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    int          mode_left = 0;
    int          cycle_count = 0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    stall_mode_t stall_mode = STALL_NONE;

    // Run statistics.
    int             fail_count = 0;
    int             bytes_taken = 0;
    int             regions_closed = 0;
    int             matches_seen = 0;
    int             settings_used = 1;
    region_result_t want;

    // Free-running clock, 10 ns period.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Lengths beyond the window size behave as a full window.
    function automatic int eff_length();
        return (plen > MAX_PATTERN) ? MAX_PATTERN : int'(plen);
    endfunction

    function automatic logic [BYTE_W-1:0] pattern_byte(int k);
        logic [2*WORD_W-1:0] both;
        both = {pat_hi, pat_lo};
        return both[8*k +: 8];
    endfunction

    // Advance the scan by one request and queue the region result on a last byte.
    function automatic void scan_byte(stream_byte_t b);
        int             len;
        logic           hit;
        region_result_t r;
        len = eff_length();
        for (int i = MAX_PATTERN - 1; i > 0; i--)
        begin
            win[i] = win[i-1];
        end
        win[0] = b.data;
        if (!seen)
        begin
            if (len == 0)
            begin
                if (pos == 0)
                begin
                    seen = 1'b1;
                    first_start = '0;
                end
            end
            else if (longint'(pos) + 1 >= longint'(len))
            begin
                hit = 1'b1;
                for (int k = 0; k < len; k++)
                begin
                    if (care[k] && pattern_byte(k) != win[len-1-k])
                        hit = 1'b0;
                end
                if (hit)
                begin
                    seen = 1'b1;
                    first_start = pos + 1 - len;
                end
            end
        end
        if (!b.last)
        begin
            pos = pos + 1;
        end
        else
        begin
            // A match must be followed by at least two more region bytes.
            r.found = seen && (longint'(first_start) + len + 1 <= longint'(pos));
            r.addr = r.found ? base + first_start + ofs : '0;
            result_q.push_back(r);
            regions_closed++;
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                win[i] = '0;
            end
            pos = '0;
            seen = 1'b0;
            first_start = '0;
        end
    endfunction

    // One configuration write: setup cycle, then access cycle.
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_PATTERN_LOW:  pat_lo = value;
            REG_PATTERN_HIGH: pat_hi = value;
            REG_CARE_MASK:    care = value[MASK_W-1:0];
            REG_PATTERN_LEN:  plen = value[LEN_W-1:0];
            REG_REGION_BASE:  base = value[ADDR_W-1:0];
            REG_RESULT_OFS:   ofs = value[ADDR_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] d, input logic l);
        stream_byte_t b;
        b.data = d;
        b.last = l;
        byte_q.push_back(b);
    endtask

    // Let everything queued go through, then allow the pipeline to settle.
    task automatic wait_idle();
        while (byte_q.size() != 0 || result_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Build one region of n bytes, optionally holding a copy of the pattern.
    task automatic queue_region(input int n, input region_kind_t kind);
        int                len;
        int                s;
        int                k;
        bit                use_alpha;
        logic [BYTE_W-1:0] bytes [$];
        len = eff_length();
        use_alpha = ($urandom_range(0, 1) == 1) && (len > 0);
        for (int i = 0; i < n; i++)
        begin
            bytes.push_back(use_alpha ? pattern_byte($urandom_range(0, len - 1))
                                      : BYTE_W'($urandom));
        end
        if (kind != REGION_NOISE && len > 0 && n >= len)
        begin
            // Tail regions end the copy on the last or second-to-last byte.
            if (kind == REGION_TAIL)
                s = n - len - ((n > len) ? int'($urandom_range(0, 1)) : 0);
            else
                s = $urandom_range(0, n - len);
            for (int j = 0; j < len; j++)
            begin
                bytes[s+j] = care[j] ? pattern_byte(j) : BYTE_W'($urandom);
            end
            // Near misses corrupt one byte that must match.
            if (kind == REGION_NEAR_MISS && (32'(care) & ((32'd1 << len) - 1)) != 0)
            begin
                k = $urandom_range(0, len - 1);
                while (!care[k])
                    k = $urandom_range(0, len - 1);
                bytes[s+k] = bytes[s+k] ^ BYTE_W'(1 << $urandom_range(0, 7));
            end
        end
        for (int i = 0; i < n; i++)
        begin
            push_byte(bytes[i], i == n - 1);
        end
    endtask

    // Take accepted requests into the scan model.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            scan_byte(byte_q[0]);
            void'(byte_q.pop_front());
            bytes_taken++;
            if (burst_left > 0)
                burst_left--;
        end
    end

    // Sender: bursts of requests separated by idle gaps.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (burst_left == 0 && gap_left > 0)
        begin
            gap_left--;
            in_valid <= 1'b0;
        end
        else
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 48);
                gap_left = ($urandom_range(0, 9) < 4) ? 0 : int'($urandom_range(1, 8));
            end
            if (byte_q.size() > 0)
            begin
                in_valid <= 1'b1;
                data_byte <= byte_q[0].data;
                last_byte <= byte_q[0].last;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: randomly chosen stall modes, plus one long hold.
    always @(negedge clk)
    begin
        cycle_count++;
        if (hold_req && !hold_done)
        begin
            hold_left = 400;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE:     out_stall <= 1'b0;
                STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
                STALL_PERIODIC: out_stall <= (cycle_count % 3 == 0);
                default:        out_stall <= 1'b0;
            endcase
        end
    end

    // Compare each region result against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (result_q.size() == 0)
            begin
                $error("unexpected result: found=%0b match_address=%h", found, match_address);
                fail_count++;
            end
            else
            begin
                want = result_q.pop_front();
                if (found !== want.found)
                begin
                    $error("found: expected %0b, got %0b", want.found, found);
                    fail_count++;
                end
                if (match_address !== want.addr)
                begin
                    $error("match_address: expected %h, got %h", want.addr, match_address);
                    fail_count++;
                end
                if (want.found)
                    matches_seen++;
            end
        end
    end

    // Main sequence: reset, directed regions, then random phases.
    initial
    begin
        int           random_items;
        int           phase;
        int           phase_items;
        int           phase_goal;
        int           n;
        int           len;
        int           pick;
        region_kind_t kind;
        logic [WORD_W-1:0] value;

        random_items = 0;
        phase = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: one-byte pattern 00. Short region, a match, a match too late.
        push_byte(8'h00, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h11, 1'b0);
        push_byte(8'h22, 1'b1);
        push_byte(8'h11, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h22, 1'b1);
        wait_idle();

        // Empty pattern with the address sum wrapping.
        reg_write(REG_PATTERN_LEN, 64'd0);
        reg_write(REG_REGION_BASE, 64'hFFFF_FFFF);
        reg_write(REG_RESULT_OFS, 64'd2);
        push_byte(8'h5A, 1'b1);
        push_byte(8'hA5, 1'b0);
        push_byte(8'h5A, 1'b1);
        wait_idle();

        // Three-byte pattern with a wildcard in the middle, region left open.
        reg_write(REG_PATTERN_LOW, 64'h0000_0000_0080_00FF);
        reg_write(REG_CARE_MASK, 64'h0005);
        reg_write(REG_PATTERN_LEN, 64'd3);
        reg_write(REG_REGION_BASE, 64'h1000);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h7E, 1'b0);
        push_byte(8'h80, 1'b0);
        wait_idle();

        // Shorter length in force at the last byte lets the earlier match through.
        reg_write(REG_PATTERN_LEN, 64'd1);
        push_byte(8'h09, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        wait_idle();

        // All-ones pattern, base and offset.
        reg_write(REG_PATTERN_LOW, '1);
        reg_write(REG_PATTERN_HIGH, '1);
        reg_write(REG_CARE_MASK, 64'hFFFF);
        reg_write(REG_PATTERN_LEN, 64'd2);
        reg_write(REG_REGION_BASE, 64'hFFFF_FFFF);
        reg_write(REG_RESULT_OFS, 64'hFFFF_FFFF);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        wait_idle();

        // Random phases: new settings, then a batch of regions, then drain.
        while (random_items < 1830)
        begin
            settings_used++;
            pick = $urandom_range(0, 9);
            value = {$urandom, $urandom};
            reg_write(REG_PATTERN_LOW, (pick == 0) ? '0 : (pick == 1) ? '1 : value);
            value = {$urandom, $urandom};
            reg_write(REG_PATTERN_HIGH, (pick == 0) ? '0 : (pick == 1) ? '1 : value);
            pick = $urandom_range(0, 9);
            reg_write(REG_CARE_MASK, (pick < 4) ? 64'hFFFF : (pick == 4) ? 64'h0
                                                 : 64'($urandom_range(0, 16'hFFFF)));
            pick = $urandom_range(0, 19);
            if (pick < 10)
                value = 64'($urandom_range(1, 6));
            else if (pick < 14)
                value = 64'($urandom_range(7, 15));
            else if (pick < 16)
                value = 64'd16;
            else if (pick < 17)
                value = 64'd0;
            else
                value = 64'($urandom_range(17, 31));
            reg_write(REG_PATTERN_LEN, value);
            pick = $urandom_range(0, 5);
            reg_write(REG_REGION_BASE, (pick == 0) ? 64'h0 : (pick == 1) ? 64'hFFFF_FFFF
                                                   : 64'($urandom));
            pick = $urandom_range(0, 5);
            reg_write(REG_RESULT_OFS, (pick == 0) ? 64'h0 : (pick == 1) ? 64'hFFFF_FFFF
                                                  : 64'($urandom));
            len = eff_length();
            phase_items = 0;

            if (phase == 2)
            begin
                // Results pile up behind a long receiver hold while bytes keep coming.
                hold_req = 1'b1;
                for (int r = 0; r < 40; r++)
                begin
                    n = len + 2 + $urandom_range(0, 2);
                    queue_region(n, REGION_PLANTED);
                    phase_items += n;
                end
            end
            else
            begin
                phase_goal = $urandom_range(60, 160);
                while (phase_items < phase_goal)
                begin
                    case ($urandom_range(0, 9))
                        0:       n = $urandom_range(1, 3);
                        1:       n = $urandom_range(20, 60);
                        default: n = len + $urandom_range(0, 10);
                    endcase
                    if (n < 1)
                        n = 1;
                    pick = $urandom_range(0, 19);
                    if (pick < 11)
                        kind = REGION_PLANTED;
                    else if (pick < 14)
                        kind = REGION_TAIL;
                    else if (pick < 17)
                        kind = REGION_NEAR_MISS;
                    else
                        kind = REGION_NOISE;
                    queue_region(n, kind);
                    phase_items += n;
                end
            end
            random_items += phase_items;
            phase++;
            wait_idle();
        end

        wait_idle();
        repeat (10) @(negedge clk);
        $display("Scanned %0d bytes in %0d regions under %0d register settings;",
                 bytes_taken, regions_closed, settings_used);
        $display("%0d regions reported a match.", matches_seen);
        if (fail_count == 0 && result_q.size() == 0 && byte_q.size() == 0)
            $display("masked_byte_pattern_search test passed");
        else
            $display("masked_byte_pattern_search test failed");
        $finish;
    end

    // Watchdog in case the block stops responding.
    initial
    begin
        #3_000_000;
        $display("masked_byte_pattern_search test failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/mbps_pkg.sv
rtl/core/mbps_regs.sv
rtl/core/mbps_match.sv
rtl/core/masked_byte_pattern_search.sv
tb/sv/masked_byte_pattern_search_tb.sv
